/* rtl/core/imlt_pkg.sv */
`timescale 1ns / 1ps

package imlt_pkg;

    localparam int MaxIntervals = 64;
    localparam int IdxW = $clog2(MaxIntervals);
    localparam int CntW = IdxW + 1;
    localparam int TimeW = 32;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_MERGE  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RD,
        S_SORT_WAIT,
        S_SORT_CMP,
        S_SORT_WR,
        S_MRG_RD,
        S_MRG_STEP,
        S_MRG_MAX,
        S_MRG_LAST,
        S_Q_RD,
        S_Q_STEP,
        S_Q_CHK_RD,
        S_Q_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [TimeW-1:0] s;
        logic [TimeW-1:0] e;
    } pair_t;

endpackage

/* rtl/core/imlt_ram.sv */
`timescale 1ns / 1ps

module imlt_ram #(
    parameter int Depth = 64,
    parameter int Width = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/interval_merge_lookup_table_unit.sv */
`timescale 1ns / 1ps
// channel | handshake            | payload                                    | dir
// s_      | s_valid, s_ready     | s_operation, s_start/end/query_time        | in
// m_      | m_valid, m_ready     | m_status, m_found_index, m_merged_count    | out
// cfg     | cfg_valid, cfg_ready | cfg_data (gap_threshold)                   | in
// clear and insert: accepted in idle, then the result is held in S_OUT
// query: a binary search (at most 7 steps for 64 entries), then a check of the candidate
// merge: straight to the result on an empty list, else an insertion sort into the scratch
//   copy, then one pass that joins entries into the merged table
// one shared 64-bit less-than unit does every time and key compare; s_ready and cfg_ready are high
// only in idle, and a result waiting on m_ready holds the block in S_OUT
// aresetn is synchronous active low; it clears counts, threshold and the sequencer

module interval_merge_lookup_table_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [31:0]           s_start_time,
    input  logic [31:0]           s_end_time,
    input  logic [31:0]           s_query_time,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [5:0]            m_found_index,
    output logic [6:0]            m_merged_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data
);
    import imlt_pkg::*;

    state_t state_reg, state_next;
    logic [TimeW-1:0] gap_reg;
    logic [CntW-1:0] raw_cnt_reg, raw_cnt_next, mrg_cnt_reg, mrg_cnt_next;
    logic [TimeW-1:0] qt_reg, qt_next;
    // sort/merge/search indexes
    logic [CntW-1:0] i_reg, i_next, j_reg, j_next, lo_reg, lo_next, hi_reg, hi_next;
    pair_t key_reg, key_next, cur_reg, cur_next;
    status_t stat_reg, stat_next;
    logic [IdxW-1:0] fidx_reg, fidx_next;

    // raw list
    logic raw_we;
    logic [IdxW-1:0] raw_waddr, raw_raddr;
    pair_t raw_wdata, raw_rdata;
    // sorted scratch copy
    logic srt_we;
    logic [IdxW-1:0] srt_waddr, srt_raddr;
    pair_t srt_wdata, srt_rdata;
    // merged table
    logic mt_we;
    logic [IdxW-1:0] mt_waddr, mt_raddr;
    pair_t mt_wdata, mt_rdata;

    imlt_ram #(.Depth(MaxIntervals), .Width(2*TimeW)) u_raw (
        .aclk, .we(raw_we), .waddr(raw_waddr), .wdata(raw_wdata),
        .raddr(raw_raddr), .rdata(raw_rdata));
    imlt_ram #(.Depth(MaxIntervals), .Width(2*TimeW)) u_srt (
        .aclk, .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
        .raddr(srt_raddr), .rdata(srt_rdata));
    imlt_ram #(.Depth(MaxIntervals), .Width(2*TimeW)) u_mt (
        .aclk, .we(mt_we), .waddr(mt_waddr), .wdata(mt_wdata),
        .raddr(mt_raddr), .rdata(mt_rdata));

    logic s_acc, m_acc;
    op_t s_op;
    logic raw_full;
    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;
    assign s_op = op_t'(s_operation);
    assign raw_full = (raw_cnt_reg == CntW'(MaxIntervals));
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    // threshold only changes while nothing is in work
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_status = stat_reg;
    assign m_found_index = fidx_reg;
    assign m_merged_count = mrg_cnt_reg;

    // index arithmetic for the sequencer
    logic [CntW-1:0] i_inc, j_dec, j_dec2, lo_dec, mid;
    logic last_entry;
    assign i_inc = i_reg + CntW'(1);
    assign j_dec = j_reg - CntW'(1);
    assign j_dec2 = j_reg - CntW'(2);
    assign lo_dec = lo_reg - CntW'(1);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign last_entry = (i_inc == raw_cnt_reg);

    // shared less-than unit; a pair compares as one 64-bit word, start in the high half
    logic [2*TimeW-1:0] cmp_a, cmp_b;
    logic cmp_lt;
    logic [TimeW:0] limit;
    // 33-bit sum so a large threshold never wraps
    assign limit = {1'b0, cur_reg.e} + {1'b0, gap_reg};
    assign cmp_lt = (cmp_a < cmp_b);

    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            S_SORT_CMP: begin
                // key below the sorted entry: shift that entry up
                cmp_a = key_reg;
                cmp_b = srt_rdata;
            end
            S_MRG_STEP: begin
                // next start below running end plus gap: join
                cmp_a = {{TimeW{1'b0}}, srt_rdata.s};
                cmp_b = {{(TimeW-1){1'b0}}, limit};
            end
            S_MRG_MAX: begin
                cmp_a = {{TimeW{1'b0}}, cur_reg.e};
                cmp_b = {{TimeW{1'b0}}, key_reg.e};
            end
            S_Q_STEP: begin
                // time below the probed start: search the lower half
                cmp_a = {{TimeW{1'b0}}, qt_reg};
                cmp_b = {{TimeW{1'b0}}, mt_rdata.s};
            end
            S_Q_CHK: begin
                // end below the time: past the candidate interval
                cmp_a = {{TimeW{1'b0}}, mt_rdata.e};
                cmp_b = {{TimeW{1'b0}}, qt_reg};
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (s_op)
                        OP_MERGE: state_next = (raw_cnt_reg == '0) ? S_OUT : S_SORT_RD;
                        OP_QUERY: state_next = S_Q_RD;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_SORT_RD:   state_next = S_SORT_WAIT;
            S_SORT_WAIT: state_next = (j_reg == '0) ? S_SORT_WR : S_SORT_CMP;
            S_SORT_CMP:  state_next = (cmp_lt && j_reg != CntW'(1)) ? S_SORT_CMP : S_SORT_WR;
            S_SORT_WR:   state_next = last_entry ? S_MRG_RD : S_SORT_RD;
            S_MRG_RD:    state_next = S_MRG_STEP;
            S_MRG_STEP: begin
                if (i_reg != '0 && cmp_lt) state_next = S_MRG_MAX;
                else state_next = last_entry ? S_MRG_LAST : S_MRG_RD;
            end
            S_MRG_MAX:   state_next = last_entry ? S_MRG_LAST : S_MRG_RD;
            S_MRG_LAST:  state_next = S_OUT;
            S_Q_RD:      state_next = (lo_reg < hi_reg) ? S_Q_STEP : S_Q_CHK_RD;
            S_Q_STEP:    state_next = S_Q_RD;
            S_Q_CHK_RD:  state_next = (lo_reg == '0) ? S_OUT : S_Q_CHK;
            S_Q_CHK:     state_next = S_OUT;
            S_OUT:       state_next = m_acc ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        i_next = i_reg; j_next = j_reg; lo_next = lo_reg; hi_next = hi_reg;
        key_next = key_reg; cur_next = cur_reg; stat_next = stat_reg;
        fidx_next = fidx_reg; mrg_cnt_next = mrg_cnt_reg; raw_cnt_next = raw_cnt_reg;
        qt_next = qt_reg;
        raw_we = 1'b0; raw_waddr = raw_cnt_reg[IdxW-1:0];
        raw_wdata = pair_t'{s: s_start_time, e: s_end_time};
        raw_raddr = i_reg[IdxW-1:0];
        srt_we = 1'b0; srt_waddr = j_reg[IdxW-1:0]; srt_wdata = key_reg;
        srt_raddr = i_reg[IdxW-1:0];
        mt_we = 1'b0; mt_waddr = mrg_cnt_reg[IdxW-1:0]; mt_wdata = cur_reg;
        mt_raddr = mid[IdxW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                stat_next = ST_OK; fidx_next = '0;
                i_next = '0; lo_next = '0; hi_next = mrg_cnt_reg;
                if (s_acc) begin
                    qt_next = s_query_time;
                    unique case (s_op)
                        OP_CLEAR: raw_cnt_next = '0;
                        OP_INSERT: begin
                            // full list drops the pair
                            if (raw_full) begin
                                stat_next = ST_FULL;
                            end else begin
                                raw_we = 1'b1;
                                raw_cnt_next = raw_cnt_reg + CntW'(1);
                            end
                        end
                        OP_MERGE: mrg_cnt_next = '0;
                        default: ;
                    endcase
                end
            end
            S_SORT_RD: j_next = i_reg;
            S_SORT_WAIT: begin
                key_next = raw_rdata;
                srt_raddr = j_dec[IdxW-1:0];
            end
            S_SORT_CMP: begin
                if (cmp_lt) begin
                    srt_we = 1'b1; srt_wdata = srt_rdata;
                    j_next = j_dec;
                    srt_raddr = j_dec2[IdxW-1:0];
                end
            end
            S_SORT_WR: begin
                srt_we = 1'b1;
                i_next = last_entry ? '0 : i_inc;
            end
            S_MRG_STEP: begin
                key_next = srt_rdata;
                if (i_reg == '0) begin
                    cur_next = srt_rdata;
                end else if (!cmp_lt) begin
                    mt_we = 1'b1;
                    mrg_cnt_next = mrg_cnt_reg + CntW'(1);
                    cur_next = srt_rdata;
                end
                if (i_reg == '0 || !cmp_lt) i_next = i_inc;
            end
            S_MRG_MAX: begin
                if (cmp_lt) cur_next.e = key_reg.e;
                i_next = i_inc;
            end
            S_MRG_LAST: begin
                mt_we = 1'b1;
                mrg_cnt_next = mrg_cnt_reg + CntW'(1);
            end
            S_Q_STEP: begin
                if (cmp_lt) hi_next = mid;
                else lo_next = mid + CntW'(1);
            end
            S_Q_CHK_RD: begin
                mt_raddr = lo_dec[IdxW-1:0];
                if (lo_reg == '0) stat_next = ST_NOTFOUND;
            end
            S_Q_CHK: begin
                if (cmp_lt) stat_next = ST_NOTFOUND;
                else fidx_next = lo_dec[IdxW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            gap_reg <= '0;
            raw_cnt_reg <= '0;
            mrg_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            raw_cnt_reg <= raw_cnt_next;
            mrg_cnt_reg <= mrg_cnt_next;
            if (cfg_valid && cfg_ready) gap_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next; j_reg <= j_next;
        lo_reg <= lo_next; hi_reg <= hi_next;
        key_reg <= key_next; cur_reg <= cur_next;
        stat_reg <= stat_next; fidx_reg <= fidx_next;
        qt_reg <= qt_next;
    end

    property p_ready_idle;
        @(posedge aclk) disable iff (!aresetn) s_ready |-> !m_valid;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready while result pending");

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        mrg_cnt_reg <= CntW'(MaxIntervals) && raw_cnt_reg <= CntW'(MaxIntervals))
        else $error("count beyond table size");

    a_busy_after_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_ready) else $error("accepted two items back to back");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_found_index) && $stable(m_merged_count))
        else $error("result item changed while waiting");

endmodule
